/* design/rvm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvm_pkg
// shared types and constants of the register machine instruction executor
// ----------------------------------------------------------------------------
package rvm_pkg;

  localparam int DATA_W    = 32;
  localparam int DIV_CNT_W = 5;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = 5'd31;

  typedef enum logic [3:0] {
    OP_MOVE  = 4'd0,
    OP_ADD   = 4'd1,
    OP_SUB   = 4'd2,
    OP_MUL   = 4'd3,
    OP_DIV   = 4'd4,
    OP_MOD   = 4'd5,
    OP_PRINT = 4'd6,
    OP_EXIT  = 4'd7,
    OP_ERROR = 4'd8
  } op_t;

  typedef enum logic [2:0] {
    ST_DONE    = 3'd0,
    ST_PRINTED = 3'd1,
    ST_EXIT    = 3'd2,
    ST_ERROR   = 3'd3,
    ST_IGNORED = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DIV,
    S_FIN
  } state_t;

  typedef struct packed {
    logic start;
    logic want_rem;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] result;
  } div_rsp_t;

endpackage

/* design/rvm_regfile.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvm_regfile
// register file memory, two registered read ports and one write port;
// entries not yet written read as zero
// ----------------------------------------------------------------------------
module rvm_regfile #(
  parameter int NUM_REGS = 16,
  parameter int IDX_W    = 4
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      rd_en,
  input  logic [IDX_W-1:0]          ra_addr,
  input  logic [IDX_W-1:0]          rb_addr,
  output logic [rvm_pkg::DATA_W-1:0] ra_data,
  output logic [rvm_pkg::DATA_W-1:0] rb_data,
  input  logic                      wr_en,
  input  logic [IDX_W-1:0]          wr_addr,
  input  logic [rvm_pkg::DATA_W-1:0] wr_data
);

  logic [rvm_pkg::DATA_W-1:0] mem [NUM_REGS];
  logic [NUM_REGS-1:0]        vld_r;
  logic [NUM_REGS-1:0]        vld_nxt;
  logic [rvm_pkg::DATA_W-1:0] da_r;
  logic [rvm_pkg::DATA_W-1:0] db_r;
  logic                       va_r;
  logic                       vb_r;

  always_comb begin
    vld_nxt = vld_r;
    if (wr_en) begin
      vld_nxt[wr_addr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      da_r <= mem[ra_addr];
      db_r <= mem[rb_addr];
      va_r <= vld_r[ra_addr];
      vb_r <= vld_r[rb_addr];
    end
  end

  assign ra_data = va_r ? da_r : '0;
  assign rb_data = vb_r ? db_r : '0;

endmodule

/* design/rvm_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvm_div
// signed 32-bit divide / remainder, radix-2 restoring, one bit per cycle,
// truncating toward zero
// ----------------------------------------------------------------------------
module rvm_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  rvm_pkg::div_req_t          req,
  input  logic [rvm_pkg::DATA_W-1:0] dividend,
  input  logic [rvm_pkg::DATA_W-1:0] divisor,
  output rvm_pkg::div_rsp_t          rsp
);

  logic                          busy_r, busy_nxt;
  logic                          fin_r, fin_nxt;
  logic [rvm_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [rvm_pkg::DATA_W-1:0]    rem_r, rem_nxt;
  logic [rvm_pkg::DATA_W-1:0]    quo_r, quo_nxt;
  logic [rvm_pkg::DATA_W-1:0]    dvs_r, dvs_nxt;
  logic                          neg_q_r, neg_q_nxt;
  logic                          neg_r_r, neg_r_nxt;
  logic                          want_rem_r, want_rem_nxt;
  logic [rvm_pkg::DATA_W:0]      trial;
  logic                          ge;

  assign trial = {rem_r, quo_r[rvm_pkg::DATA_W-1]} - {1'b0, dvs_r};
  assign ge    = !trial[rvm_pkg::DATA_W];

  always_comb begin
    busy_nxt     = busy_r;
    fin_nxt      = 1'b0;
    cnt_nxt      = cnt_r;
    rem_nxt      = rem_r;
    quo_nxt      = quo_r;
    dvs_nxt      = dvs_r;
    neg_q_nxt    = neg_q_r;
    neg_r_nxt    = neg_r_r;
    want_rem_nxt = want_rem_r;
    if (req.start) begin
      busy_nxt     = 1'b1;
      cnt_nxt      = '0;
      rem_nxt      = '0;
      quo_nxt      = dividend[rvm_pkg::DATA_W-1] ? (~dividend + 1'b1) : dividend;
      dvs_nxt      = divisor[rvm_pkg::DATA_W-1] ? (~divisor + 1'b1) : divisor;
      neg_q_nxt    = dividend[rvm_pkg::DATA_W-1] ^ divisor[rvm_pkg::DATA_W-1];
      neg_r_nxt    = dividend[rvm_pkg::DATA_W-1];
      want_rem_nxt = req.want_rem;
    end else if (busy_r) begin
      rem_nxt = ge ? trial[rvm_pkg::DATA_W-1:0]
                   : {rem_r[rvm_pkg::DATA_W-2:0], quo_r[rvm_pkg::DATA_W-1]};
      quo_nxt = {quo_r[rvm_pkg::DATA_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == rvm_pkg::DIV_LAST) begin
        busy_nxt = 1'b0;
        fin_nxt  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      fin_r  <= fin_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    dvs_r      <= dvs_nxt;
    neg_q_r    <= neg_q_nxt;
    neg_r_r    <= neg_r_nxt;
    want_rem_r <= want_rem_nxt;
  end

  always_comb begin
    rsp.done = fin_r;
    if (want_rem_r) begin
      rsp.result = neg_r_r ? (~rem_r + 1'b1) : rem_r;
    end else begin
      rsp.result = neg_q_r ? (~quo_r + 1'b1) : quo_r;
    end
  end

endmodule

/* design/register_vm_instruction_executor.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// register_vm_instruction_executor
// runs one register machine instruction per input beat against a file of
// NUM_REGS signed 32-bit registers and returns one status beat per instruction
// ----------------------------------------------------------------------------
// usage
//   input beat: op, register indexes, move form and immediate; taken when
//   in_valid is high and in_stall is low. in_stall is high while an
//   instruction is in flight, so one instruction is worked on at a time.
//   output beat: status and print value, held in an output register until
//   taken (out_valid high, out_stall low); the next instruction is accepted
//   while that beat still waits.
//   sequence: move, add, sub, mul, print and exit pass through the
//   execute and final states, items ignored while halted go straight to
//   the final state, and div and mod wait in the divide state between them
//   while the one-bit-per-cycle divider runs its 32 iterations.
//   the register file is a memory with registered reads, read in the accept
//   cycle and written back when the result beat is loaded.
//   reset clears the halt flag and the per-entry valid bits, so all
//   registers read as zero; no clearing pass is needed.
//   a stalled receiver holds the block in its final state until the output
//   register frees up; nothing is dropped.
// ----------------------------------------------------------------------------
module register_vm_instruction_executor #(
  parameter int NUM_REGS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [3:0]         in_op,
  input  logic [3:0]         in_dest_reg,
  input  logic [3:0]         in_src_a_reg,
  input  logic [3:0]         in_src_b_reg,
  input  logic               in_const_form,
  input  logic signed [31:0] in_immediate,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_status,
  output logic signed [31:0] out_print_value
);

  localparam int IDX_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

  rvm_pkg::state_t            state_r, state_nxt;
  logic                       halted_r, halted_nxt;
  logic [3:0]                 op_r;
  logic [3:0]                 d_r;
  logic [3:0]                 sa_r;
  logic [3:0]                 sb_r;
  logic                       cf_r;
  logic [31:0]                imm_r;
  rvm_pkg::status_t           st_r, st_nxt;
  logic [31:0]                res_r, res_nxt;
  logic                       wr_r, wr_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [2:0]                 out_status_r;
  logic [31:0]                out_pv_r;

  logic                       accept;
  logic                       fin_go;
  logic [31:0]                a_val;
  logic [31:0]                b_val;
  logic                       ok_d, ok_a, ok_b;
  rvm_pkg::status_t           ex_status;
  logic [31:0]                ex_res;
  logic                       ex_wr;
  logic                       ex_div;
  rvm_pkg::div_req_t          div_req;
  rvm_pkg::div_rsp_t          div_rsp;

  rvm_regfile #(
    .NUM_REGS (NUM_REGS),
    .IDX_W    (IDX_W)
  ) u_regfile (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .ra_addr (IDX_W'(in_src_a_reg)),
    .rb_addr (IDX_W'(in_src_b_reg)),
    .ra_data (a_val),
    .rb_data (b_val),
    .wr_en   (fin_go && wr_r),
    .wr_addr (IDX_W'(d_r)),
    .wr_data (res_r)
  );

  rvm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .dividend (a_val),
    .divisor  (b_val),
    .rsp      (div_rsp)
  );

  assign ok_d = 32'(d_r) < 32'(NUM_REGS);
  assign ok_a = 32'(sa_r) < 32'(NUM_REGS);
  assign ok_b = 32'(sb_r) < 32'(NUM_REGS);

  // instruction decode and execute; div and mod are checked here and handed to the divider
  always_comb begin
    ex_status = rvm_pkg::ST_DONE;
    ex_res    = '0;
    ex_wr     = 1'b0;
    ex_div    = 1'b0;
    unique case (op_r) inside
      rvm_pkg::OP_MOVE: begin
        if (!cf_r || !ok_d) begin
          ex_status = rvm_pkg::ST_ERROR;
        end else begin
          ex_res = imm_r;
          ex_wr  = 1'b1;
        end
      end
      rvm_pkg::OP_ADD, rvm_pkg::OP_SUB, rvm_pkg::OP_MUL: begin
        if (!ok_d || !ok_a || !ok_b) begin
          ex_status = rvm_pkg::ST_ERROR;
        end else begin
          ex_wr = 1'b1;
          if (op_r == rvm_pkg::OP_ADD) begin
            ex_res = a_val + b_val;
          end else if (op_r == rvm_pkg::OP_SUB) begin
            ex_res = a_val - b_val;
          end else begin
            ex_res = a_val * b_val;
          end
        end
      end
      rvm_pkg::OP_DIV, rvm_pkg::OP_MOD: begin
        if (!ok_d || !ok_a || !ok_b || (b_val == '0)) begin
          ex_status = rvm_pkg::ST_ERROR;
        end else begin
          ex_wr  = 1'b1;
          ex_div = 1'b1;
        end
      end
      rvm_pkg::OP_PRINT: begin
        if (!ok_a) begin
          ex_status = rvm_pkg::ST_ERROR;
        end else begin
          ex_status = rvm_pkg::ST_PRINTED;
          ex_res    = a_val;
        end
      end
      rvm_pkg::OP_EXIT: begin
        ex_status = rvm_pkg::ST_EXIT;
      end
      default: begin
        ex_status = rvm_pkg::ST_ERROR;
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rvm_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = halted_r ? rvm_pkg::S_FIN : rvm_pkg::S_EXEC;
        end
      end
      rvm_pkg::S_EXEC: begin
        state_nxt = ex_div ? rvm_pkg::S_DIV : rvm_pkg::S_FIN;
      end
      rvm_pkg::S_DIV: begin
        if (div_rsp.done) begin
          state_nxt = rvm_pkg::S_FIN;
        end
      end
      rvm_pkg::S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = rvm_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = rvm_pkg::S_IDLE;
      end
    endcase
  end

  // state outputs
  always_comb begin
    in_stall         = 1'b1;
    accept           = 1'b0;
    fin_go           = 1'b0;
    div_req.start    = 1'b0;
    div_req.want_rem = (op_r == rvm_pkg::OP_MOD);
    unique case (state_r)
      rvm_pkg::S_IDLE: begin
        in_stall = 1'b0;
        accept   = in_valid;
      end
      rvm_pkg::S_EXEC: begin
        div_req.start = ex_div;
      end
      rvm_pkg::S_DIV: begin
      end
      rvm_pkg::S_FIN: begin
        fin_go = !out_valid_r || !out_stall;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    st_nxt  = st_r;
    res_nxt = res_r;
    wr_nxt  = wr_r;
    if (accept && halted_r) begin
      st_nxt  = rvm_pkg::ST_IGNORED;
      res_nxt = '0;
      wr_nxt  = 1'b0;
    end else if (state_r == rvm_pkg::S_EXEC) begin
      st_nxt  = ex_status;
      res_nxt = ex_res;
      wr_nxt  = ex_wr;
    end else if (state_r == rvm_pkg::S_DIV && div_rsp.done) begin
      res_nxt = div_rsp.result;
    end
  end

  always_comb begin
    halted_nxt = halted_r;
    if (fin_go && (st_r == rvm_pkg::ST_EXIT || st_r == rvm_pkg::ST_ERROR)) begin
      halted_nxt = 1'b1;
    end
    out_valid_nxt = out_valid_r;
    if (fin_go) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rvm_pkg::S_IDLE;
      halted_r    <= 1'b0;
      out_valid_r <= 1'b0;
      wr_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      halted_r    <= halted_nxt;
      out_valid_r <= out_valid_nxt;
      wr_r        <= wr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= in_op;
      d_r   <= in_dest_reg;
      sa_r  <= in_src_a_reg;
      sb_r  <= in_src_b_reg;
      cf_r  <= in_const_form;
      imm_r <= in_immediate;
    end
    st_r  <= st_nxt;
    res_r <= res_nxt;
    if (fin_go) begin
      out_status_r <= st_r;
      out_pv_r     <= (st_r == rvm_pkg::ST_PRINTED) ? res_r : '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_print_value = out_pv_r;

  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |=> halted_r)
    else $error("halt flag cleared without reset");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> state_r == rvm_pkg::S_DIV)
    else $error("divider finished outside the divide state");

  a_write_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (fin_go && wr_r) |-> st_r == rvm_pkg::ST_DONE)
    else $error("register write on a non-executed instruction");

  a_ignored_when_halted: assert property (@(posedge clk) disable iff (!rst_n)
    (fin_go && halted_r) |=> out_status_r == rvm_pkg::ST_IGNORED)
    else $error("instruction executed while halted");

endmodule

/* test/register_vm_instruction_executor_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// register_vm_instruction_executor_tb
// Drives instruction beats into the register machine executor and checks
// every status beat against a behavioral copy of the register file and the
// halt flag. A short directed run covers the wrap, signed division and print
// corners. About a thousand random arithmetic, move and print instructions
// follow. One randomly chosen halting case (exit, error opcode, unknown
// opcode, bad move form, divide or remainder by zero) ends the program. Then
// a tail of fully random beats must all come back as ignored. The sender
// works in bursts with gaps between them, and the receiver stalls in
// changing patterns.
// ----------------------------------------------------------------------------
module register_vm_instruction_executor_tb;

  localparam int REG_COUNT = 16;
  localparam int IDLE_LIMIT = 3000;
  localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] WORD_MAX = 32'sh7fff_ffff;

  class rvm_scoreboard;
    logic signed [31:0] regs [REG_COUNT];
    bit halted;
    logic [2:0] want_status [$];
    logic signed [31:0] want_value [$];
    int errors;

    function new();
      foreach (regs[i]) regs[i] = '0;
      halted = 1'b0;
      errors = 0;
    endfunction

    task report(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    function logic signed [31:0] signed_divide(
      input logic signed [31:0] a, input logic signed [31:0] b, input bit want_rem);
      if (a == WORD_MIN && b == -32'sd1) return want_rem ? 32'sd0 : WORD_MIN;
      return want_rem ? a % b : a / b;
    endfunction

    function void note_instruction(input logic [3:0] op, input logic [3:0] dst,
                                   input logic [3:0] src_a, input logic [3:0] src_b,
                                   input logic cf, input logic signed [31:0] imm);
      logic [2:0] st;
      logic signed [31:0] pv;
      logic signed [31:0] a;
      logic signed [31:0] b;
      st = rvm_pkg::ST_DONE;
      pv = '0;
      if (halted) begin
        st = rvm_pkg::ST_IGNORED;
      end else begin
        case (op)
          rvm_pkg::OP_MOVE: begin
            if (!cf || dst >= REG_COUNT) st = rvm_pkg::ST_ERROR;
            else regs[dst] = imm;
          end
          rvm_pkg::OP_ADD, rvm_pkg::OP_SUB, rvm_pkg::OP_MUL, rvm_pkg::OP_DIV,
          rvm_pkg::OP_MOD: begin
            if (dst >= REG_COUNT || src_a >= REG_COUNT || src_b >= REG_COUNT) begin
              st = rvm_pkg::ST_ERROR;
            end else begin
              a = regs[src_a];
              b = regs[src_b];
              if ((op == rvm_pkg::OP_DIV || op == rvm_pkg::OP_MOD) && b == 0)
                st = rvm_pkg::ST_ERROR;
              else if (op == rvm_pkg::OP_ADD) regs[dst] = a + b;
              else if (op == rvm_pkg::OP_SUB) regs[dst] = a - b;
              else if (op == rvm_pkg::OP_MUL) regs[dst] = a * b;
              else regs[dst] = signed_divide(a, b, op == rvm_pkg::OP_MOD);
            end
          end
          rvm_pkg::OP_PRINT: begin
            if (src_a >= REG_COUNT) begin
              st = rvm_pkg::ST_ERROR;
            end else begin
              st = rvm_pkg::ST_PRINTED;
              pv = regs[src_a];
            end
          end
          rvm_pkg::OP_EXIT: st = rvm_pkg::ST_EXIT;
          default: st = rvm_pkg::ST_ERROR;
        endcase
      end
      if (st == rvm_pkg::ST_EXIT || st == rvm_pkg::ST_ERROR) halted = 1'b1;
      want_status.push_back(st);
      want_value.push_back(pv);
    endfunction

    task check_status_beat(input logic [2:0] st, input logic signed [31:0] pv);
      logic [2:0] exp_st;
      logic signed [31:0] exp_pv;
      if (want_status.size() == 0) begin
        report($sformatf("unexpected beat status %0d value %0d", st, pv));
      end else begin
        exp_st = want_status.pop_front();
        exp_pv = want_value.pop_front();
        if (st !== exp_st)
          report($sformatf("status got %0d want %0d", st, exp_st));
        if (pv !== exp_pv)
          report($sformatf("print value got %0d want %0d", pv, exp_pv));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [3:0] in_op = '0;
  logic [3:0] in_dest_reg = '0;
  logic [3:0] in_src_a_reg = '0;
  logic [3:0] in_src_b_reg = '0;
  logic in_const_form = 1'b0;
  logic signed [31:0] in_immediate = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] out_status;
  logic signed [31:0] out_print_value;

  rvm_scoreboard board;
  int burst_left = 0;
  int stall_left = 0;
  int stall_mode = 0;
  int idle_cycles = 0;

  register_vm_instruction_executor #(.NUM_REGS(REG_COUNT)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_op(in_op),
    .in_dest_reg(in_dest_reg),
    .in_src_a_reg(in_src_a_reg),
    .in_src_b_reg(in_src_b_reg),
    .in_const_form(in_const_form),
    .in_immediate(in_immediate),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_status(out_status),
    .out_print_value(out_print_value)
  );

  always #5 clk = ~clk;

  task automatic send_instr(input logic [3:0] op, input logic [3:0] dst,
                            input logic [3:0] src_a, input logic [3:0] src_b,
                            input logic cf, input logic signed [31:0] imm);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 40);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_op <= op;
    in_dest_reg <= dst;
    in_src_a_reg <= src_a;
    in_src_b_reg <= src_b;
    in_const_form <= cf;
    in_immediate <= imm;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_instruction(op, dst, src_a, src_b, cf, imm);
  endtask

  // receiver stall pattern: free, light, heavy, periodic
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(30, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= ((stall_left % 5) < 3);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_status_beat(out_status, out_print_value);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("register_vm_instruction_executor_tb failed");
      $finish;
    end
  end

  initial begin
    logic [3:0] op;
    logic [3:0] dst;
    logic [3:0] src_a;
    logic [3:0] src_b;
    logic signed [31:0] imm;
    int pick;
    board = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corners
    send_instr(rvm_pkg::OP_PRINT, 4'd0, 4'd0, 4'd0, 1'b1, 32'sd0);
    send_instr(rvm_pkg::OP_MOVE, 4'd1, 4'd0, 4'd0, 1'b1, WORD_MAX);
    send_instr(rvm_pkg::OP_MOVE, 4'd2, 4'd0, 4'd0, 1'b1, WORD_MIN);
    send_instr(rvm_pkg::OP_MOVE, 4'd3, 4'd0, 4'd0, 1'b1, -32'sd1);
    send_instr(rvm_pkg::OP_MOVE, 4'd4, 4'd0, 4'd0, 1'b1, 32'sd1);
    send_instr(rvm_pkg::OP_MOVE, 4'd11, 4'd15, 4'd15, 1'b1, -32'sd7);
    send_instr(rvm_pkg::OP_MOVE, 4'd12, 4'd0, 4'd0, 1'b1, 32'sd2);
    send_instr(rvm_pkg::OP_ADD, 4'd6, 4'd1, 4'd4, 1'b0, -32'sd1);
    send_instr(rvm_pkg::OP_SUB, 4'd7, 4'd2, 4'd4, 1'b1, 32'sd0);
    send_instr(rvm_pkg::OP_MUL, 4'd8, 4'd1, 4'd1, 1'b0, 32'sd0);
    send_instr(rvm_pkg::OP_MUL, 4'd5, 4'd2, 4'd3, 1'b1, 32'sd0);
    send_instr(rvm_pkg::OP_DIV, 4'd9, 4'd2, 4'd3, 1'b1, 32'sd0);
    send_instr(rvm_pkg::OP_MOD, 4'd10, 4'd2, 4'd3, 1'b0, 32'sd0);
    send_instr(rvm_pkg::OP_DIV, 4'd13, 4'd11, 4'd12, 1'b1, 32'sd0);
    send_instr(rvm_pkg::OP_MOD, 4'd14, 4'd11, 4'd12, 1'b1, 32'sd0);
    send_instr(rvm_pkg::OP_DIV, 4'd15, 4'd1, 4'd2, 1'b1, 32'sd0);
    send_instr(rvm_pkg::OP_MOD, 4'd0, 4'd2, 4'd1, 1'b1, 32'sd0);
    send_instr(rvm_pkg::OP_ADD, 4'd15, 4'd15, 4'd15, 1'b1, 32'sd0);
    send_instr(rvm_pkg::OP_PRINT, 4'd0, 4'd6, 4'd0, 1'b1, 32'sd0);
    send_instr(rvm_pkg::OP_PRINT, 4'd0, 4'd7, 4'd0, 1'b0, 32'sd0);
    send_instr(rvm_pkg::OP_PRINT, 4'd0, 4'd8, 4'd0, 1'b1, 32'sd0);
    send_instr(rvm_pkg::OP_PRINT, 4'd0, 4'd9, 4'd0, 1'b1, 32'sd0);
    send_instr(rvm_pkg::OP_PRINT, 4'd0, 4'd10, 4'd0, 1'b1, 32'sd0);
    send_instr(rvm_pkg::OP_PRINT, 4'd0, 4'd13, 4'd0, 1'b1, 32'sd0);
    send_instr(rvm_pkg::OP_PRINT, 4'd0, 4'd14, 4'd0, 1'b1, 32'sd0);

    // random program that never halts
    for (int n = 0; n < 1100; n++) begin
      pick = $urandom_range(0, 99);
      dst = 4'($urandom_range(0, 15));
      src_a = 4'($urandom_range(0, 15));
      src_b = 4'($urandom_range(0, 15));
      if (pick < 30) op = rvm_pkg::OP_MOVE;
      else if (pick < 40) op = rvm_pkg::OP_ADD;
      else if (pick < 50) op = rvm_pkg::OP_SUB;
      else if (pick < 60) op = rvm_pkg::OP_MUL;
      else if (pick < 72) op = rvm_pkg::OP_DIV;
      else if (pick < 84) op = rvm_pkg::OP_MOD;
      else op = rvm_pkg::OP_PRINT;
      case ($urandom_range(0, 5))
        0: imm = WORD_MIN;
        1: imm = WORD_MAX;
        2: imm = $signed($urandom_range(0, 6)) - 32'sd3;
        3: imm = $signed($urandom_range(0, 2000)) - 32'sd1000;
        default: imm = $urandom;
      endcase
      if ((op == rvm_pkg::OP_DIV || op == rvm_pkg::OP_MOD) && board.regs[src_b] == 0)
        op = rvm_pkg::OP_SUB;
      send_instr(op, dst, src_a, src_b,
                 (op == rvm_pkg::OP_MOVE) ? 1'b1 : 1'($urandom_range(0, 1)), imm);
    end

    // one halting case, then beats that must all be ignored
    dst = 4'($urandom_range(0, 15));
    src_a = 4'($urandom_range(0, 15));
    case ($urandom_range(0, 5))
      0: send_instr(rvm_pkg::OP_EXIT, dst, src_a, 4'd0, 1'b1, $urandom);
      1: send_instr(rvm_pkg::OP_ERROR, dst, src_a, 4'd0, 1'b1, $urandom);
      2: send_instr(4'($urandom_range(9, 15)), dst, src_a, 4'd0, 1'b1, $urandom);
      3: send_instr(rvm_pkg::OP_MOVE, dst, src_a, 4'd0, 1'b0, $urandom);
      default: begin
        send_instr(rvm_pkg::OP_MOVE, 4'd0, 4'd0, 4'd0, 1'b1, 32'sd0);
        send_instr($urandom_range(0, 1) ? rvm_pkg::OP_DIV : rvm_pkg::OP_MOD,
                   dst, src_a, 4'd0, 1'b1, 32'sd0);
      end
    endcase
    for (int n = 0; n < 24; n++)
      send_instr(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                 1'($urandom_range(0, 1)), $urandom);
    in_valid <= 1'b0;

    while (board.want_status.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (board.want_status.size() != 0)
      board.report($sformatf("%0d beats never came", board.want_status.size()));
    if (board.errors == 0) begin
      $display("register_vm_instruction_executor_tb passed");
    end else begin
      $display("register_vm_instruction_executor_tb failed");
    end
    $finish;
  end

endmodule
